@@ rtl/core/pcf_pkg.sv @@
`default_nettype none

package pcf_pkg;

    localparam int MAX_VERTS_DEF  = 64;
    localparam int COORD_BITS_DEF = 24;

    localparam int OP_BITS      = 2;
    localparam int STATUS_BITS  = 2;
    localparam int FEATHER_BITS = 23;
    localparam int WEIGHT_BITS  = 16;

    // weight then inside flag, padded to whole bytes
    localparam int OUT_DATA_BITS = ((WEIGHT_BITS + 1 + 7) / 8) * 8;

    localparam logic [OP_BITS-1:0] OP_CLEAR  = 2'd0;
    localparam logic [OP_BITS-1:0] OP_APPEND = 2'd1;
    localparam logic [OP_BITS-1:0] OP_QUERY  = 2'd2;

    localparam logic [STATUS_BITS-1:0] STAT_OK    = 2'd0;
    localparam logic [STATUS_BITS-1:0] STAT_FULL  = 2'd1;
    localparam logic [STATUS_BITS-1:0] STAT_EMPTY = 2'd2;

    localparam logic [WEIGHT_BITS-1:0] WEIGHT_ONE = 16'd32768;

    // squared distance never exceeds feather squared
    localparam int BEST_BITS  = 2 * FEATHER_BITS;
    localparam int ROOT_SHIFT = 30;
    localparam int RAD_BITS   = BEST_BITS + ROOT_SHIFT;
    localparam int ROOT_BITS  = RAD_BITS / 2;

    // vertex distance is only taken when both offsets are below this
    localparam logic signed [39:0] DIST_LIM = 40'sd16777216;

endpackage

`default_nettype wire

@@ rtl/core/pcf_div.sv @@
`default_nettype none

module pcf_div #(
    parameter int NUM_BITS = 102,
    parameter int DEN_BITS = 51
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire logic [NUM_BITS-1:0] num,
    input  wire logic [DEN_BITS-1:0] den,
    output logic      [NUM_BITS-1:0] quo,
    output logic                     done
);

    localparam int CNT_BITS = $clog2(NUM_BITS);

    logic                busy_reg;
    logic                done_reg;
    logic [CNT_BITS-1:0] cnt_reg;
    logic [NUM_BITS-1:0] num_reg;
    logic [NUM_BITS-1:0] quo_reg;
    logic [DEN_BITS-1:0] den_reg;
    logic [DEN_BITS-1:0] rem_reg;

    logic [DEN_BITS:0]   rem_sh;
    logic [DEN_BITS:0]   rem_diff;
    logic                fits;

    // restoring division, one quotient bit a cycle
    always_comb
    begin
        rem_sh   = {rem_reg, num_reg[NUM_BITS-1]};
        rem_diff = rem_sh - {1'b0, den_reg};
        fits     = rem_sh >= {1'b0, den_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_BITS'(NUM_BITS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= num;
            den_reg <= den;
            rem_reg <= '0;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            num_reg <= {num_reg[NUM_BITS-2:0], 1'b0};
            rem_reg <= fits ? rem_diff[DEN_BITS-1:0] : rem_sh[DEN_BITS-1:0];
            quo_reg <= {quo_reg[NUM_BITS-2:0], fits};
        end
    end

    assign quo  = quo_reg;
    assign done = done_reg;

endmodule

`default_nettype wire

@@ rtl/core/pcf_sqrt.sv @@
`default_nettype none

module pcf_sqrt #(
    parameter int RAD_BITS = 76
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic [RAD_BITS-1:0]   rad,
    output logic      [RAD_BITS/2-1:0] root,
    output logic                       done
);

    localparam int RW       = RAD_BITS / 2;
    localparam int CNT_BITS = $clog2(RW);

    logic                busy_reg;
    logic                done_reg;
    logic [CNT_BITS-1:0] cnt_reg;
    logic [RAD_BITS-1:0] rad_reg;
    logic [RW-1:0]       root_reg;
    logic [RW+1:0]       rem_reg;

    logic [RW+3:0]       rem_sh;
    logic [RW+3:0]       trial;
    logic [RW+3:0]       rem_diff;
    logic                fits;

    // two radicand bits in, one root bit out per cycle
    always_comb
    begin
        rem_sh   = {rem_reg, rad_reg[RAD_BITS-1:RAD_BITS-2]};
        trial    = {2'b00, root_reg, 2'b01};
        rem_diff = rem_sh - trial;
        fits     = rem_sh >= trial;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_BITS'(RW - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= rad;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg  <= {rad_reg[RAD_BITS-3:0], 2'b00};
            rem_reg  <= fits ? rem_diff[RW+1:0] : rem_sh[RW+1:0];
            root_reg <= {root_reg[RW-2:0], fits};
        end
    end

    assign root = root_reg;
    assign done = done_reg;

endmodule

`default_nettype wire

@@ rtl/core/polygon_containment_feather.sv @@
`default_nettype none

// Point-in-polygon test with feathered edge weight. Words on the input side
// clear the polygon, append a vertex or query a point; every word gives one
// result word. Clear, append and a query that misses the bounding box go
// straight to the response. A query inside the box makes one crossing pass
// over the stored ring, and when the point is inside and the feather is
// nonzero, squares the feather and makes a second pass for the nearest vertex
// or edge, adding, on edges whose foot lies on the segment and whose cross
// product fits in 63 bits, a shift-add square of the cross product and a
// restoring divide. The block has a single signed multiplier, squarer and
// divider. When the nearest distance is under the feather, the final root
// takes a square root and one more divide. Input is not taken while a query
// runs, but a new word is taken while the last result still waits on the
// output.
module polygon_containment_feather #(
    parameter int MAX_VERTS  = pcf_pkg::MAX_VERTS_DEF,
    parameter int COORD_BITS = pcf_pkg::COORD_BITS_DEF
) (
    input  wire logic                                    clk,
    input  wire logic                                    rst_n,
    input  wire logic                                    s_tvalid,
    output logic                                         s_tready,
    // coord_x, coord_z
    input  wire logic [((2*COORD_BITS+7)/8)*8-1:0]       s_tdata,
    // operation
    input  wire logic [pcf_pkg::OP_BITS-1:0]             s_tuser,
    output logic                                         m_tvalid,
    input  wire logic                                    m_tready,
    // weight, inside_res
    output logic [pcf_pkg::OUT_DATA_BITS-1:0]            m_tdata,
    // status
    output logic [pcf_pkg::STATUS_BITS-1:0]              m_tuser,
    input  wire logic                                    cfg_wr_en,
    input  wire logic [pcf_pkg::FEATHER_BITS-1:0]        cfg_wr_data
);

    import pcf_pkg::*;

    localparam int C    = COORD_BITS;
    localparam int D    = C + 1;
    localparam int SW   = 2 * D + 1;
    localparam int NW   = 2 * SW;
    localparam int AW   = $clog2(MAX_VERTS);
    localparam int CNTW = $clog2(MAX_VERTS + 1);

    localparam logic signed [C-1:0] COORD_MAX = {1'b0, {(C-1){1'b1}}};
    localparam logic signed [C-1:0] COORD_MIN = {1'b1, {(C-1){1'b0}}};

    typedef enum logic [4:0] {
        S_IDLE, S_RESP,
        S_CX_FETCH_L, S_CX_LAST, S_CX_FETCH, S_CX_TEST,
        S_CX_MUL_N, S_CX_MUL_R, S_CX_CMP, S_CX_NEXT,
        S_FSQ,
        S_PD_FETCH_L, S_PD_LAST, S_PD_FETCH, S_PD_TEST,
        S_PD_M0, S_PD_M1, S_PD_M2, S_PD_M3, S_PD_M4,
        S_PD_M5, S_PD_M6, S_PD_M7, S_PD_M8,
        S_PD_SQ, S_PD_DIV, S_PD_NEXT, S_PD_END,
        S_RT_SQRT, S_RT_DIV
    } state_t;

    state_t                   state_reg;
    logic [CNTW-1:0]          count_reg;
    logic [AW-1:0]            idx_reg;
    logic                     odd_reg;
    logic [FEATHER_BITS-1:0]  feather_reg;
    logic signed [C-1:0]      box_min_x_reg, box_max_x_reg, box_min_z_reg, box_max_z_reg;
    logic [WEIGHT_BITS-1:0]   res_weight_reg;
    logic                     res_inside_reg;
    logic [STATUS_BITS-1:0]   res_status_reg;
    logic                     m_valid_reg;
    logic [WEIGHT_BITS-1:0]   m_weight_reg;
    logic                     m_inside_reg;
    logic [STATUS_BITS-1:0]   m_status_reg;

    logic [2*C-1:0]           vmem [MAX_VERTS];
    logic [2*C-1:0]           rdata_reg;

    logic signed [C-1:0]      qx_reg, qz_reg, lx_reg, lz_reg, vx_reg, vz_reg;
    logic signed [D-1:0]      dx_reg, dz_reg, ex_reg, ez_reg, wx_reg, wz_reg;
    logic signed [2*D-1:0]    mul_reg, n_reg;
    logic signed [SW-1:0]     acc_reg;
    logic [SW-1:0]            ee_reg;
    logic [NW-1:0]            sq_a_reg, sq_acc_reg;
    logic [SW-1:0]            sq_b_reg;
    logic [BEST_BITS-1:0]     best_reg, fsq_reg;

    logic                     accept;
    logic                     resp_load;
    logic [OP_BITS-1:0]       in_op;
    logic signed [C-1:0]      in_x, in_z, rd_x, rd_z;
    logic                     full, outside, mem_we;
    logic [AW-1:0]            last_idx;
    logic                     at_last;
    logic                     cx_cond, cx_toggle;
    logic signed [D-1:0]      mul_a, mul_b;
    logic signed [SW-1:0]     mul_ext, sum_add, sum_sub, cr_abs;
    logic                     dist_ok, we_skip, cr_big, sq_done, best_ge;

    logic                     div_start, div_done;
    logic [NW-1:0]            div_num, div_quo;
    logic [SW-1:0]            div_den;
    logic                     sqrt_start, sqrt_done;
    logic [ROOT_BITS-1:0]     sqrt_root;

    assign accept    = s_tvalid && s_tready;
    assign s_tready  = (state_reg == S_IDLE);
    assign resp_load = (state_reg == S_RESP) && (!m_valid_reg || m_tready);
    assign in_op     = s_tuser;
    assign in_x      = s_tdata[C-1:0];
    assign in_z      = s_tdata[2*C-1:C];
    assign rd_x      = rdata_reg[C-1:0];
    assign rd_z      = rdata_reg[2*C-1:C];
    assign full      = (count_reg >= CNTW'(MAX_VERTS));
    assign mem_we    = accept && (in_op == OP_APPEND) && !full;
    assign last_idx  = AW'(count_reg - 1'b1);
    assign at_last   = (idx_reg == last_idx);
    assign outside   = (in_x < box_min_x_reg) || (in_x > box_max_x_reg) ||
                       (in_z < box_min_z_reg) || (in_z > box_max_z_reg);

    // edge straddles the query line
    assign cx_cond  = ((rd_z <= qz_reg) && (qz_reg < lz_reg)) ||
                      ((lz_reg <= qz_reg) && (qz_reg < rd_z));
    // n_reg = dz*ex and mul_reg = dx*ez are both negated forms of the test
    assign cx_toggle = (ez_reg < 0) ? (n_reg < mul_reg) : (n_reg > mul_reg);

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_CX_MUL_N: begin mul_a = dz_reg; mul_b = ex_reg; end
            S_CX_MUL_R: begin mul_a = dx_reg; mul_b = ez_reg; end
            S_PD_M0:    begin mul_a = dx_reg; mul_b = dx_reg; end
            S_PD_M1:    begin mul_a = dz_reg; mul_b = dz_reg; end
            S_PD_M2:    begin mul_a = ex_reg; mul_b = ex_reg; end
            S_PD_M3:    begin mul_a = ez_reg; mul_b = ez_reg; end
            S_PD_M4:    begin mul_a = wx_reg; mul_b = ex_reg; end
            S_PD_M5:    begin mul_a = wz_reg; mul_b = ez_reg; end
            S_PD_M6:    begin mul_a = wx_reg; mul_b = ez_reg; end
            S_PD_M7:    begin mul_a = wz_reg; mul_b = ex_reg; end
            default:    begin mul_a = '0; mul_b = '0; end
        endcase
    end

    assign mul_ext = $signed({mul_reg[2*D-1], mul_reg});
    assign sum_add = acc_reg + mul_ext;
    assign sum_sub = acc_reg - mul_ext;
    assign cr_abs  = (sum_sub < 0) ? -sum_sub : sum_sub;
    assign dist_ok = (dx_reg < DIST_LIM) && (dx_reg > -DIST_LIM) &&
                     (dz_reg < DIST_LIM) && (dz_reg > -DIST_LIM);
    assign we_skip = (sum_add < 0) || (sum_add > $signed(ee_reg));
    assign cr_big  = (($unsigned(cr_abs) >> 63) != '0);
    assign sq_done = (sq_b_reg == '0);
    assign best_ge = (best_reg >= fsq_reg);

    assign sqrt_start = (state_reg == S_PD_END) && !best_ge;
    assign div_start  = ((state_reg == S_PD_SQ) && sq_done) ||
                        ((state_reg == S_RT_SQRT) && sqrt_done);
    assign div_num    = (state_reg == S_RT_SQRT) ? NW'(sqrt_root) : sq_acc_reg;
    assign div_den    = (state_reg == S_RT_SQRT) ? SW'(feather_reg) : ee_reg;

    pcf_div #(
        .NUM_BITS (NW),
        .DEN_BITS (SW)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .quo   (div_quo),
        .done  (div_done)
    );

    pcf_sqrt #(
        .RAD_BITS (RAD_BITS)
    ) u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sqrt_start),
        .rad   ({best_reg, {ROOT_SHIFT{1'b0}}}),
        .root  (sqrt_root),
        .done  (sqrt_done)
    );

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            vmem[count_reg[AW-1:0]] <= {in_z, in_x};
        end
        rdata_reg <= vmem[idx_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            idx_reg        <= '0;
            odd_reg        <= 1'b0;
            feather_reg    <= '0;
            box_min_x_reg  <= COORD_MAX;
            box_min_z_reg  <= COORD_MAX;
            box_max_x_reg  <= COORD_MIN;
            box_max_z_reg  <= COORD_MIN;
            res_weight_reg <= '0;
            res_inside_reg <= 1'b0;
            res_status_reg <= STAT_OK;
            m_valid_reg    <= 1'b0;
            m_weight_reg   <= '0;
            m_inside_reg   <= 1'b0;
            m_status_reg   <= STAT_OK;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                feather_reg <= cfg_wr_data;
            end
            if (resp_load)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_valid_reg && m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        res_weight_reg <= '0;
                        res_inside_reg <= 1'b0;
                        case (in_op)
                            OP_CLEAR:
                            begin
                                res_status_reg <= STAT_OK;
                                state_reg      <= S_RESP;
                                count_reg      <= '0;
                                box_min_x_reg  <= COORD_MAX;
                                box_min_z_reg  <= COORD_MAX;
                                box_max_x_reg  <= COORD_MIN;
                                box_max_z_reg  <= COORD_MIN;
                            end
                            OP_APPEND:
                            begin
                                state_reg <= S_RESP;
                                if (full)
                                begin
                                    res_status_reg <= STAT_FULL;
                                end
                                else
                                begin
                                    res_status_reg <= STAT_OK;
                                    count_reg      <= count_reg + 1'b1;
                                    if (in_x < box_min_x_reg) box_min_x_reg <= in_x;
                                    if (in_x > box_max_x_reg) box_max_x_reg <= in_x;
                                    if (in_z < box_min_z_reg) box_min_z_reg <= in_z;
                                    if (in_z > box_max_z_reg) box_max_z_reg <= in_z;
                                end
                            end
                            OP_QUERY:
                            begin
                                if (count_reg == '0)
                                begin
                                    res_status_reg <= STAT_EMPTY;
                                    state_reg      <= S_RESP;
                                end
                                else
                                begin
                                    res_status_reg <= STAT_OK;
                                    if (!outside)
                                    begin
                                        idx_reg   <= last_idx;
                                        odd_reg   <= 1'b0;
                                        state_reg <= S_CX_FETCH_L;
                                    end
                                    else
                                    begin
                                        state_reg <= S_RESP;
                                    end
                                end
                            end
                            default:
                            begin
                                res_status_reg <= STAT_OK;
                                state_reg      <= S_RESP;
                            end
                        endcase
                    end
                end
                S_CX_FETCH_L: state_reg <= S_CX_LAST;
                S_CX_LAST:
                begin
                    idx_reg   <= '0;
                    state_reg <= S_CX_FETCH;
                end
                S_CX_FETCH:   state_reg <= S_CX_TEST;
                S_CX_TEST:    state_reg <= cx_cond ? S_CX_MUL_N : S_CX_NEXT;
                S_CX_MUL_N:   state_reg <= S_CX_MUL_R;
                S_CX_MUL_R:   state_reg <= S_CX_CMP;
                S_CX_CMP:
                begin
                    if (cx_toggle)
                    begin
                        odd_reg <= !odd_reg;
                    end
                    state_reg <= S_CX_NEXT;
                end
                S_CX_NEXT:
                begin
                    if (at_last)
                    begin
                        if (!odd_reg)
                        begin
                            state_reg <= S_RESP;
                        end
                        else if (feather_reg == '0)
                        begin
                            res_inside_reg <= 1'b1;
                            res_weight_reg <= WEIGHT_ONE;
                            state_reg      <= S_RESP;
                        end
                        else
                        begin
                            res_inside_reg <= 1'b1;
                            state_reg      <= S_FSQ;
                        end
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= S_CX_FETCH;
                    end
                end
                S_FSQ:
                begin
                    if (sq_done)
                    begin
                        idx_reg   <= last_idx;
                        state_reg <= S_PD_FETCH_L;
                    end
                end
                S_PD_FETCH_L: state_reg <= S_PD_LAST;
                S_PD_LAST:
                begin
                    idx_reg   <= '0;
                    state_reg <= S_PD_FETCH;
                end
                S_PD_FETCH:   state_reg <= S_PD_TEST;
                S_PD_TEST:    state_reg <= S_PD_M0;
                S_PD_M0:      state_reg <= S_PD_M1;
                S_PD_M1:      state_reg <= S_PD_M2;
                S_PD_M2:      state_reg <= S_PD_M3;
                S_PD_M3:      state_reg <= S_PD_M4;
                S_PD_M4:      state_reg <= (sum_add == '0) ? S_PD_NEXT : S_PD_M5;
                S_PD_M5:      state_reg <= S_PD_M6;
                S_PD_M6:      state_reg <= we_skip ? S_PD_NEXT : S_PD_M7;
                S_PD_M7:      state_reg <= S_PD_M8;
                S_PD_M8:      state_reg <= cr_big ? S_PD_NEXT : S_PD_SQ;
                S_PD_SQ:
                begin
                    if (sq_done)
                    begin
                        state_reg <= S_PD_DIV;
                    end
                end
                S_PD_DIV:
                begin
                    if (div_done)
                    begin
                        state_reg <= S_PD_NEXT;
                    end
                end
                S_PD_NEXT:
                begin
                    if (at_last)
                    begin
                        state_reg <= S_PD_END;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= S_PD_FETCH;
                    end
                end
                S_PD_END:
                begin
                    if (best_ge)
                    begin
                        res_weight_reg <= WEIGHT_ONE;
                        state_reg      <= S_RESP;
                    end
                    else
                    begin
                        state_reg <= S_RT_SQRT;
                    end
                end
                S_RT_SQRT:
                begin
                    if (sqrt_done)
                    begin
                        state_reg <= S_RT_DIV;
                    end
                end
                S_RT_DIV:
                begin
                    if (div_done)
                    begin
                        res_weight_reg <= WEIGHT_BITS'(div_quo);
                        state_reg      <= S_RESP;
                    end
                end
                S_RESP:
                begin
                    if (resp_load)
                    begin
                        m_weight_reg <= res_weight_reg;
                        m_inside_reg <= res_inside_reg;
                        m_status_reg <= res_status_reg;
                        state_reg    <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // datapath, no reset
    always_ff @(posedge clk)
    begin
        mul_reg <= mul_a * mul_b;
        case (state_reg) inside
            S_IDLE:
            begin
                if (accept)
                begin
                    qx_reg <= in_x;
                    qz_reg <= in_z;
                end
            end
            S_CX_LAST, S_PD_LAST:
            begin
                lx_reg <= rd_x;
                lz_reg <= rd_z;
            end
            S_CX_TEST, S_PD_TEST:
            begin
                vx_reg <= rd_x;
                vz_reg <= rd_z;
                dx_reg <= $signed({qx_reg[C-1], qx_reg}) - $signed({rd_x[C-1], rd_x});
                dz_reg <= $signed({qz_reg[C-1], qz_reg}) - $signed({rd_z[C-1], rd_z});
                ex_reg <= $signed({rd_x[C-1], rd_x}) - $signed({lx_reg[C-1], lx_reg});
                ez_reg <= $signed({rd_z[C-1], rd_z}) - $signed({lz_reg[C-1], lz_reg});
                wx_reg <= $signed({qx_reg[C-1], qx_reg}) - $signed({lx_reg[C-1], lx_reg});
                wz_reg <= $signed({qz_reg[C-1], qz_reg}) - $signed({lz_reg[C-1], lz_reg});
            end
            S_CX_MUL_R:
            begin
                n_reg <= mul_reg;
            end
            S_CX_NEXT:
            begin
                lx_reg     <= vx_reg;
                lz_reg     <= vz_reg;
                sq_a_reg   <= NW'(feather_reg);
                sq_b_reg   <= SW'(feather_reg);
                sq_acc_reg <= '0;
            end
            S_FSQ:
            begin
                if (sq_done)
                begin
                    fsq_reg  <= BEST_BITS'(sq_acc_reg);
                    best_reg <= BEST_BITS'(sq_acc_reg);
                end
                else
                begin
                    if (sq_b_reg[0]) sq_acc_reg <= sq_acc_reg + sq_a_reg;
                    sq_a_reg <= {sq_a_reg[NW-2:0], 1'b0};
                    sq_b_reg <= {1'b0, sq_b_reg[SW-1:1]};
                end
            end
            S_PD_M1, S_PD_M3, S_PD_M5, S_PD_M7:
            begin
                acc_reg <= mul_ext;
            end
            S_PD_M2:
            begin
                if (dist_ok && (NW'($unsigned(sum_add)) < NW'(best_reg)))
                begin
                    best_reg <= BEST_BITS'($unsigned(sum_add));
                end
            end
            S_PD_M4:
            begin
                ee_reg <= $unsigned(sum_add);
            end
            S_PD_M8:
            begin
                sq_a_reg   <= NW'($unsigned(cr_abs));
                sq_b_reg   <= $unsigned(cr_abs);
                sq_acc_reg <= '0;
            end
            S_PD_SQ:
            begin
                if (!sq_done)
                begin
                    if (sq_b_reg[0]) sq_acc_reg <= sq_acc_reg + sq_a_reg;
                    sq_a_reg <= {sq_a_reg[NW-2:0], 1'b0};
                    sq_b_reg <= {1'b0, sq_b_reg[SW-1:1]};
                end
            end
            S_PD_DIV:
            begin
                if (div_done && (div_quo < NW'(best_reg)))
                begin
                    best_reg <= BEST_BITS'(div_quo);
                end
            end
            S_PD_NEXT:
            begin
                lx_reg <= vx_reg;
                lz_reg <= vz_reg;
            end
            default:
            begin
            end
        endcase
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(OUT_DATA_BITS-WEIGHT_BITS-1){1'b0}}, m_inside_reg, m_weight_reg};
    assign m_tuser  = m_status_reg;

`ifndef NO_ASSERTIONS
    a_weight_max: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[WEIGHT_BITS-1:0] <= WEIGHT_ONE))
        else $error("weight above one");

    a_outside_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tdata[WEIGHT_BITS]) |-> (m_tdata[WEIGHT_BITS-1:0] == '0))
        else $error("nonzero weight for point not inside");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNTW'(MAX_VERTS))
        else $error("vertex count past store depth");
`endif

endmodule

`default_nettype wire
